// ===== hdl/stunrp_pkg.sv =====
// Shared types and protocol constants for the STUN response parser.
`timescale 1ns / 1ps
`default_nettype none

package stunrp_pkg;

  localparam logic [31:0] MAGIC_COOKIE  = 32'h2112_A442;
  localparam logic [15:0] T_BIND_OK     = 16'h0101;
  localparam logic [15:0] T_ALLOC_OK    = 16'h0103;
  localparam logic [15:0] A_XOR_MAPPED  = 16'h0020;
  localparam logic [15:0] A_MAPPED      = 16'h0001;
  localparam logic [15:0] A_XOR_RELAYED = 16'h0016;
  localparam logic [15:0] A_LIFETIME    = 16'h000D;
  localparam logic [7:0]  FAMILY_IPV4   = 8'h01;

  localparam int HDR_BYTES = 20;

  typedef enum logic [1:0] {
    PH_HEADER   = 2'd0,
    PH_ATTR_HDR = 2'd1,
    PH_VALUE    = 2'd2,
    PH_PAD      = 2'd3
  } phase_t;

  typedef enum logic [2:0] {
    ST_BIND_FOUND   = 3'd0,
    ST_ALLOC        = 3'd1,
    ST_SHORT        = 3'd2,
    ST_BAD_COOKIE   = 3'd3,
    ST_OTHER_TYPE   = 3'd4,
    ST_BIND_NO_ADDR = 3'd5
  } status_t;

endpackage

`default_nettype wire

// ===== hdl/stun_response_parser_top.sv =====
// STUN/TURN response parser: byte-stream header check, attribute walk, result register.
// Latency: a result beat is valid the cycle after the last byte of a datagram is accepted.
// Throughput: one byte per clock; every byte updates the parse state in the cycle it
//   is accepted, so only a last byte can stall, and only while an earlier result is held.
// Reset: rst (synchronous, active high) clears the parse state and drops out_valid.
// After each result the parse state returns to its reset values for the next datagram.
`timescale 1ns / 1ps
`default_nettype none

module stun_response_parser_top
  import stunrp_pkg::*;
#(
  parameter int MAX_MESSAGE_BYTES = 2048
) (
  input  wire logic        clk,
  input  wire logic        rst,
  // byte beats
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [7:0]  data_byte,
  input  wire logic        last_byte,
  // result beats
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [2:0]       status,
  output logic [15:0]      message_type,
  output logic [31:0]      mapped_ip,
  output logic [15:0]      mapped_port,
  output logic             mapped_valid,
  output logic [31:0]      relayed_ip,
  output logic [15:0]      relayed_port,
  output logic             relayed_valid,
  output logic [31:0]      lifetime_seconds,
  output logic             lifetime_valid,
  output logic [31:0]      txid_high,
  output logic [63:0]      txid_low
);

  // byte offset saturates at MAX_MESSAGE_BYTES; later bytes are dropped
  localparam int OFF_W = $clog2(MAX_MESSAGE_BYTES + 1);
  localparam logic [OFF_W-1:0] OFF_MAX = OFF_W'(MAX_MESSAGE_BYTES);

  // ---------------------------------------------------------------------------
  // Parse state
  // ---------------------------------------------------------------------------
  logic [OFF_W-1:0] byte_offset, byte_offset_next;
  logic [15:0]      header_type, header_type_next;
  logic [15:0]      header_length, header_length_next;
  logic [31:0]      cookie_shift, cookie_shift_next;
  logic [31:0]      txid_upper_reg, txid_upper_reg_next;
  logic [63:0]      txid_lower_reg, txid_lower_reg_next;
  phase_t           attr_phase, attr_phase_next;
  logic [15:0]      attr_type_reg, attr_type_reg_next;
  logic [15:0]      attr_length_reg, attr_length_reg_next;
  logic [15:0]      attr_byte_count, attr_byte_count_next;
  logic [63:0]      value_shift, value_shift_next;
  logic             walk_stopped, walk_stopped_next;

  // kept attribute results
  logic [31:0]      map_ip, map_ip_next;
  logic [15:0]      map_port, map_port_next;
  logic             map_vld, map_vld_next;
  logic [31:0]      rel_ip, rel_ip_next;
  logic [15:0]      rel_port, rel_port_next;
  logic             rel_vld, rel_vld_next;
  logic [31:0]      life_sec, life_sec_next;
  logic             life_vld, life_vld_next;

  // ---------------------------------------------------------------------------
  // Handshake: non-last bytes never produce a beat, so they flow even while a
  // result is held. A last byte waits for the result register to free up.
  // ---------------------------------------------------------------------------
  logic in_fire, take_byte, in_walk, load_result;

  assign in_ready    = !out_valid || out_ready || !last_byte;
  assign in_fire     = in_valid && in_ready;
  assign take_byte   = in_fire && (byte_offset < OFF_MAX);
  assign in_walk     = take_byte && (byte_offset >= OFF_W'(HDR_BYTES)) && !walk_stopped;
  assign load_result = in_fire && last_byte;

  // ---------------------------------------------------------------------------
  // Attribute walk helpers
  // ---------------------------------------------------------------------------
  logic [15:0] cnt_inc;
  logic [15:0] type_shifted, len_shifted;
  logic [63:0] value_new;
  logic        hdr_stop, hdr_done, val_done, pad_done;
  logic [1:0]  pad;

  assign cnt_inc      = attr_byte_count + 16'd1;
  assign type_shifted = (attr_byte_count < 16'd2) ? {attr_type_reg[7:0], data_byte}
                                                  : attr_type_reg;
  assign len_shifted  = (attr_byte_count >= 16'd2) ? {attr_length_reg[7:0], data_byte}
                                                   : attr_length_reg;
  assign value_new    = (attr_byte_count < 16'd8) ? {value_shift[55:0], data_byte}
                                                  : value_shift;
  // stop when the next attribute header would run past the declared length
  assign hdr_stop     = (attr_byte_count == 16'd0) &&
                        ((18'(byte_offset) + 18'd4) > (18'(HDR_BYTES) + 18'(header_length)));
  assign hdr_done     = (cnt_inc == 16'd4);
  assign val_done     = (cnt_inc == attr_length_reg);
  assign pad          = 2'd0 - attr_length_reg[1:0];
  assign pad_done     = (cnt_inc >= {14'd0, pad});

  // decode of the attribute that completes on this byte
  logic        addr_ok;
  logic [15:0] plain_port, xor_port;
  logic [31:0] plain_ip, xor_ip, life_val;
  logic        is_bind_hdr;

  assign addr_ok     = (attr_length_reg >= 16'd8) && (value_new[55:48] == FAMILY_IPV4);
  assign plain_port  = value_new[47:32];
  assign plain_ip    = value_new[31:0];
  assign xor_port    = plain_port ^ MAGIC_COOKIE[31:16];
  assign xor_ip      = plain_ip ^ MAGIC_COOKIE;
  assign is_bind_hdr = (header_type == T_BIND_OK);

  // lifetime takes the first four value bytes, at most eight are held
  always_comb begin
    if (attr_length_reg >= 16'd8) begin
      life_val = value_new[63:32];
    end else begin
      case (attr_length_reg[1:0])
        2'd0:    life_val = value_new[31:0];
        2'd1:    life_val = value_new[39:8];
        2'd2:    life_val = value_new[47:16];
        default: life_val = value_new[55:24];
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Phase next state
  // ---------------------------------------------------------------------------
  always_comb begin
    attr_phase_next = attr_phase;
    if (take_byte && (byte_offset == OFF_W'(HDR_BYTES - 1))) begin
      attr_phase_next = PH_ATTR_HDR;
    end else if (in_walk) begin
      unique case (attr_phase)
        PH_HEADER: attr_phase_next = PH_HEADER;
        PH_ATTR_HDR: begin
          if (!hdr_stop && hdr_done && (len_shifted != 16'd0)) begin
            attr_phase_next = PH_VALUE;
          end
        end
        PH_VALUE: begin
          if (val_done) begin
            attr_phase_next = (pad != 2'd0) ? PH_PAD : PH_ATTR_HDR;
          end
        end
        PH_PAD: begin
          if (pad_done) begin
            attr_phase_next = PH_ATTR_HDR;
          end
        end
        default: attr_phase_next = PH_HEADER;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Datapath next state
  // ---------------------------------------------------------------------------
  always_comb begin
    byte_offset_next     = byte_offset;
    header_type_next     = header_type;
    header_length_next   = header_length;
    cookie_shift_next    = cookie_shift;
    txid_upper_reg_next  = txid_upper_reg;
    txid_lower_reg_next  = txid_lower_reg;
    attr_type_reg_next   = attr_type_reg;
    attr_length_reg_next = attr_length_reg;
    attr_byte_count_next = attr_byte_count;
    value_shift_next     = value_shift;
    walk_stopped_next    = walk_stopped;
    map_ip_next          = map_ip;
    map_port_next        = map_port;
    map_vld_next         = map_vld;
    rel_ip_next          = rel_ip;
    rel_port_next        = rel_port;
    rel_vld_next         = rel_vld;
    life_sec_next        = life_sec;
    life_vld_next        = life_vld;

    if (take_byte) begin
      byte_offset_next = byte_offset + OFF_W'(1);
      if (byte_offset < OFF_W'(2)) begin
        header_type_next = {header_type[7:0], data_byte};
      end else if (byte_offset < OFF_W'(4)) begin
        header_length_next = {header_length[7:0], data_byte};
      end else if (byte_offset < OFF_W'(8)) begin
        cookie_shift_next = {cookie_shift[23:0], data_byte};
      end else if (byte_offset < OFF_W'(12)) begin
        txid_upper_reg_next = {txid_upper_reg[23:0], data_byte};
      end else if (byte_offset < OFF_W'(HDR_BYTES)) begin
        txid_lower_reg_next = {txid_lower_reg[55:0], data_byte};
      end
    end

    if (in_walk) begin
      unique case (attr_phase)
        PH_HEADER: begin
        end
        PH_ATTR_HDR: begin
          if (hdr_stop) begin
            walk_stopped_next = 1'b1;
          end else begin
            attr_type_reg_next   = type_shifted;
            attr_length_reg_next = len_shifted;
            attr_byte_count_next = cnt_inc;
            if (hdr_done) begin
              attr_byte_count_next = 16'd0;
              value_shift_next     = 64'd0;
              // a zero-length attribute carries nothing to keep
              if (len_shifted == 16'd0) begin
                attr_type_reg_next = 16'd0;
              end
            end
          end
        end
        PH_VALUE: begin
          value_shift_next     = value_new;
          attr_byte_count_next = cnt_inc;
          if (val_done) begin
            attr_byte_count_next = 16'd0;
            attr_type_reg_next   = 16'd0;
            if (pad == 2'd0) begin
              attr_length_reg_next = 16'd0;
            end
            if (is_bind_hdr) begin
              // first usable reflexive address wins and ends the walk
              if (addr_ok && (attr_type_reg == A_XOR_MAPPED ||
                              attr_type_reg == A_MAPPED)) begin
                map_vld_next      = 1'b1;
                walk_stopped_next = 1'b1;
                if (attr_type_reg == A_XOR_MAPPED) begin
                  map_ip_next   = xor_ip;
                  map_port_next = xor_port;
                end else begin
                  map_ip_next   = plain_ip;
                  map_port_next = plain_port;
                end
              end
            end else if (attr_type_reg == A_XOR_RELAYED && addr_ok) begin
              rel_vld_next  = 1'b1;
              rel_ip_next   = xor_ip;
              rel_port_next = xor_port;
            end else if (attr_type_reg == A_XOR_MAPPED && addr_ok) begin
              map_vld_next  = 1'b1;
              map_ip_next   = xor_ip;
              map_port_next = xor_port;
            end else if (attr_type_reg == A_LIFETIME && attr_length_reg >= 16'd4) begin
              life_vld_next = 1'b1;
              life_sec_next = life_val;
            end
          end
        end
        PH_PAD: begin
          attr_byte_count_next = cnt_inc;
          if (pad_done) begin
            attr_byte_count_next = 16'd0;
            attr_length_reg_next = 16'd0;
          end
        end
        default: begin
        end
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Result beat built from the state as it stands after the last byte
  // ---------------------------------------------------------------------------
  status_t     res_status;
  logic [15:0] res_type;
  logic [31:0] res_map_ip, res_rel_ip, res_life, res_txid_hi;
  logic [15:0] res_map_port, res_rel_port;
  logic        res_map_vld, res_rel_vld, res_life_vld;
  logic [63:0] res_txid_lo;

  always_comb begin
    res_status   = ST_SHORT;
    res_type     = 16'd0;
    res_map_ip   = 32'd0;
    res_map_port = 16'd0;
    res_map_vld  = 1'b0;
    res_rel_ip   = 32'd0;
    res_rel_port = 16'd0;
    res_rel_vld  = 1'b0;
    res_life     = 32'd0;
    res_life_vld = 1'b0;
    res_txid_hi  = 32'd0;
    res_txid_lo  = 64'd0;
    if (byte_offset_next >= OFF_W'(HDR_BYTES)) begin
      res_type    = header_type_next;
      res_txid_hi = txid_upper_reg_next;
      res_txid_lo = txid_lower_reg_next;
      if (cookie_shift_next != MAGIC_COOKIE) begin
        res_status = ST_BAD_COOKIE;
      end else if (header_type_next == T_BIND_OK || header_type_next == T_ALLOC_OK) begin
        if (map_vld_next) begin
          res_map_ip   = map_ip_next;
          res_map_port = map_port_next;
          res_map_vld  = 1'b1;
        end
        if (header_type_next == T_BIND_OK) begin
          res_status = map_vld_next ? ST_BIND_FOUND : ST_BIND_NO_ADDR;
        end else begin
          res_status = ST_ALLOC;
          if (rel_vld_next) begin
            res_rel_ip   = rel_ip_next;
            res_rel_port = rel_port_next;
            res_rel_vld  = 1'b1;
          end
          if (life_vld_next) begin
            res_life     = life_sec_next;
            res_life_vld = 1'b1;
          end
        end
      end else begin
        res_status = ST_OTHER_TYPE;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Registers
  // ---------------------------------------------------------------------------
  // parse state: cleared by reset and after every datagram
  always_ff @(posedge clk) begin
    if (rst || load_result) begin
      byte_offset     <= '0;
      header_type     <= '0;
      header_length   <= '0;
      cookie_shift    <= '0;
      txid_upper_reg  <= '0;
      txid_lower_reg  <= '0;
      attr_phase      <= PH_HEADER;
      attr_type_reg   <= '0;
      attr_length_reg <= '0;
      attr_byte_count <= '0;
      value_shift     <= '0;
      walk_stopped    <= 1'b0;
      map_ip          <= '0;
      map_port        <= '0;
      map_vld         <= 1'b0;
      rel_ip          <= '0;
      rel_port        <= '0;
      rel_vld         <= 1'b0;
      life_sec        <= '0;
      life_vld        <= 1'b0;
    end else if (in_fire) begin
      byte_offset     <= byte_offset_next;
      header_type     <= header_type_next;
      header_length   <= header_length_next;
      cookie_shift    <= cookie_shift_next;
      txid_upper_reg  <= txid_upper_reg_next;
      txid_lower_reg  <= txid_lower_reg_next;
      attr_phase      <= attr_phase_next;
      attr_type_reg   <= attr_type_reg_next;
      attr_length_reg <= attr_length_reg_next;
      attr_byte_count <= attr_byte_count_next;
      value_shift     <= value_shift_next;
      walk_stopped    <= walk_stopped_next;
      map_ip          <= map_ip_next;
      map_port        <= map_port_next;
      map_vld         <= map_vld_next;
      rel_ip          <= rel_ip_next;
      rel_port        <= rel_port_next;
      rel_vld         <= rel_vld_next;
      life_sec        <= life_sec_next;
      life_vld        <= life_vld_next;
    end
  end

  // result beat holder
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_result) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_result) begin
      status           <= res_status;
      message_type     <= res_type;
      mapped_ip        <= res_map_ip;
      mapped_port      <= res_map_port;
      mapped_valid     <= res_map_vld;
      relayed_ip       <= res_rel_ip;
      relayed_port     <= res_rel_port;
      relayed_valid    <= res_rel_vld;
      lifetime_seconds <= res_life;
      lifetime_valid   <= res_life_vld;
      txid_high        <= res_txid_hi;
      txid_low         <= res_txid_lo;
    end
  end

`ifndef SYNTHESIS
  // a last byte always leaves a result beat behind it
  assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready && last_byte) |=> out_valid)
    else $error("no result beat after last byte");

  // a new result beat only follows a last byte
  assert property (@(posedge clk) disable iff (rst)
    (out_valid && !$past(out_valid)) |-> $past(in_valid && in_ready && last_byte))
    else $error("result beat without last byte");

  // short datagrams carry nothing but the status
  assert property (@(posedge clk) disable iff (rst)
    (out_valid && status == ST_SHORT) |->
      (!mapped_valid && !relayed_valid && !lifetime_valid && message_type == 16'd0))
    else $error("short result carries fields");

  // relayed address and lifetime belong to allocate results only
  assert property (@(posedge clk) disable iff (rst)
    (out_valid && (relayed_valid || lifetime_valid)) |-> (status == ST_ALLOC))
    else $error("allocate fields on non-allocate result");

  // the walk can only stop once the header is through
  assert property (@(posedge clk) disable iff (rst)
    walk_stopped |-> (attr_phase != PH_HEADER))
    else $error("walk stopped during header");
`endif

endmodule

`default_nettype wire

// ===== tb/tb_top.sv =====
// Self-checking bench for stun_response_parser_top: table of directed datagrams, then random traffic.
`timescale 1ns / 1ps

module tb_top;
  import stunrp_pkg::*;

  localparam int MAX_MSG    = 256;
  localparam int RAND_BYTES = 1000;

  // Table column: expectation typed into the row, or worked out by the parse model below.
  localparam bit PINNED    = 1'b1;
  localparam bit PREDICTED = 1'b0;

  typedef struct packed {
    status_t     status;
    logic [15:0] msg_type;
    logic [31:0] map_ip;
    logic [15:0] map_port;
    logic        map_ok;
    logic [31:0] rel_ip;
    logic [15:0] rel_port;
    logic        rel_ok;
    logic [31:0] life;
    logic        life_ok;
    logic [31:0] tx_hi;
    logic [63:0] tx_lo;
  } stun_result_t;

  // One TLV attribute; val holds the first eight value bytes, first byte on top.
  typedef struct packed {
    logic [15:0] atype;
    logic [15:0] alen;
    logic [63:0] val;
  } attr_t;

  // Recipe for one datagram.
  typedef struct {
    logic [15:0] mtype;
    logic [31:0] cookie;
    logic [95:0] txid;
    int          len_adj;  // added to the true attribute byte count for the length field
    int          cut;      // keep only this many bytes (0: keep all)
    int          total;    // pad with random bytes up to this size (0: no pad)
    int          nattr;
    attr_t [2:0] attrs;
    bit          pin;
    status_t     pin_st;
  } msg_spec_t;

  typedef struct {
    bit           pin;
    stun_result_t res;
  } dgram_note_t;

  localparam attr_t       NO_ATTR = '0;
  localparam logic [95:0] TX_A    = 96'h0123_4567_89AB_CDEF_0F1E_2D3C;

  // ---------------------------------------------------------------------------
  // Clock, reset, block under test
  // ---------------------------------------------------------------------------
  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [7:0]  data_byte = 8'h00;
  logic        last_byte = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [2:0]  status;
  logic [15:0] message_type;
  logic [31:0] mapped_ip;
  logic [15:0] mapped_port;
  logic        mapped_valid;
  logic [31:0] relayed_ip;
  logic [15:0] relayed_port;
  logic        relayed_valid;
  logic [31:0] lifetime_seconds;
  logic        lifetime_valid;
  logic [31:0] txid_high;
  logic [63:0] txid_low;

  initial begin
    forever #10 clk = ~clk;
  end

  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;
  end

  stun_response_parser_top #(.MAX_MESSAGE_BYTES(MAX_MSG)) u_dut (.*);

  // Idle chances in percent, per cycle, for the byte sender and the result receiver.
  int src_idle = 0;
  int dst_idle = 0;

  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= dst_idle);
  end

  // ---------------------------------------------------------------------------
  // Parse model: follows the byte stream exactly as the parser should
  // ---------------------------------------------------------------------------
  logic [16:0] prs_off;
  logic [15:0] prs_type;
  logic [15:0] prs_len;
  logic [31:0] prs_cookie;
  logic [31:0] prs_txh;
  logic [63:0] prs_txl;
  phase_t      prs_phase;
  logic [15:0] at_type;
  logic [15:0] at_len;
  logic [15:0] at_cnt;
  logic [63:0] at_val;
  logic        walk_done;
  logic [31:0] keep_map_ip;
  logic [15:0] keep_map_port;
  logic        keep_map_ok;
  logic [31:0] keep_rel_ip;
  logic [15:0] keep_rel_port;
  logic        keep_rel_ok;
  logic [31:0] keep_life;
  logic        keep_life_ok;

  function automatic void clear_parse();
    prs_off       = '0;
    prs_type      = '0;
    prs_len       = '0;
    prs_cookie    = '0;
    prs_txh       = '0;
    prs_txl       = '0;
    prs_phase     = PH_HEADER;
    at_type       = '0;
    at_len        = '0;
    at_cnt        = '0;
    at_val        = '0;
    walk_done     = 1'b0;
    keep_map_ip   = '0;
    keep_map_port = '0;
    keep_map_ok   = 1'b0;
    keep_rel_ip   = '0;
    keep_rel_port = '0;
    keep_rel_ok   = 1'b0;
    keep_life     = '0;
    keep_life_ok  = 1'b0;
  endfunction

  // Attribute complete: decide whether it updates the kept fields.
  function automatic void close_attr();
    logic        addr_ok;
    logic [15:0] port;
    logic [31:0] ip;
    int          n;
    addr_ok = (at_len >= 16'd8) && (at_val[55:48] == FAMILY_IPV4);
    port    = at_val[47:32];
    ip      = at_val[31:0];
    if (prs_type == T_BIND_OK) begin
      // binding: first good mapped address wins and ends the walk
      if (addr_ok && (at_type == A_XOR_MAPPED || at_type == A_MAPPED)) begin
        if (at_type == A_XOR_MAPPED) begin
          port ^= MAGIC_COOKIE[31:16];
          ip   ^= MAGIC_COOKIE;
        end
        keep_map_ip   = ip;
        keep_map_port = port;
        keep_map_ok   = 1'b1;
        walk_done     = 1'b1;
      end
    end else if (at_type == A_XOR_RELAYED && addr_ok) begin
      keep_rel_ip   = ip ^ MAGIC_COOKIE;
      keep_rel_port = port ^ MAGIC_COOKIE[31:16];
      keep_rel_ok   = 1'b1;
    end else if (at_type == A_XOR_MAPPED && addr_ok) begin
      keep_map_ip   = ip ^ MAGIC_COOKIE;
      keep_map_port = port ^ MAGIC_COOKIE[31:16];
      keep_map_ok   = 1'b1;
    end else if (at_type == A_LIFETIME && at_len >= 16'd4) begin
      // first four value bytes, wherever they sit in the shift register
      n            = (at_len < 16'd8) ? int'(at_len) : 8;
      keep_life    = 32'(at_val >> ((n - 4) * 8));
      keep_life_ok = 1'b1;
    end
  endfunction

  function automatic void walk_attr(logic [16:0] pos, logic [7:0] b);
    logic [1:0] pad;
    if (walk_done) return;
    case (prs_phase)
      PH_ATTR_HDR: begin
        // an attribute header that would run past the declared length stops the walk
        if (at_cnt == 16'd0 && 32'(pos) + 32'd4 > 32'(HDR_BYTES) + 32'(prs_len)) begin
          walk_done = 1'b1;
          return;
        end
        if (at_cnt < 16'd2) at_type = {at_type[7:0], b};
        else at_len = {at_len[7:0], b};
        at_cnt++;
        if (at_cnt == 16'd4) begin
          at_cnt = '0;
          at_val = '0;
          if (at_len == 16'd0) begin
            close_attr();
            at_type = '0;
          end else begin
            prs_phase = PH_VALUE;
          end
        end
      end
      PH_VALUE: begin
        if (at_cnt < 16'd8) at_val = {at_val[55:0], b};
        at_cnt++;
        if (at_cnt == at_len) begin
          pad = 2'd0 - at_len[1:0];
          close_attr();
          at_cnt    = '0;
          at_type   = '0;
          prs_phase = (pad != 2'd0) ? PH_PAD : PH_ATTR_HDR;
          if (pad == 2'd0) at_len = '0;
        end
      end
      PH_PAD: begin
        pad = 2'd0 - at_len[1:0];
        at_cnt++;
        if (at_cnt >= 16'(pad)) begin
          at_cnt    = '0;
          at_len    = '0;
          prs_phase = PH_ATTR_HDR;
        end
      end
      default: ;
    endcase
  endfunction

  // Feed one accepted byte; returns 1 with the result when the byte ends a datagram.
  function automatic bit parse_byte(logic [7:0] b, logic last, output stun_result_t r);
    logic [16:0] pos;
    pos = prs_off;
    r   = '0;
    if (pos < MAX_MSG) begin
      if (pos < 2) prs_type = {prs_type[7:0], b};
      else if (pos < 4) prs_len = {prs_len[7:0], b};
      else if (pos < 8) prs_cookie = {prs_cookie[23:0], b};
      else if (pos < 12) prs_txh = {prs_txh[23:0], b};
      else if (pos < HDR_BYTES) prs_txl = {prs_txl[55:0], b};
      else walk_attr(pos, b);
      if (pos == HDR_BYTES - 1) prs_phase = PH_ATTR_HDR;
      prs_off = pos + 17'd1;
    end
    if (!last) return 1'b0;
    if (prs_off < HDR_BYTES) begin
      r.status = ST_SHORT;
    end else begin
      r.msg_type = prs_type;
      r.tx_hi    = prs_txh;
      r.tx_lo    = prs_txl;
      if (prs_cookie != MAGIC_COOKIE) begin
        r.status = ST_BAD_COOKIE;
      end else if (prs_type == T_BIND_OK || prs_type == T_ALLOC_OK) begin
        if (keep_map_ok) begin
          r.map_ip   = keep_map_ip;
          r.map_port = keep_map_port;
          r.map_ok   = 1'b1;
        end
        if (prs_type == T_BIND_OK) begin
          r.status = keep_map_ok ? ST_BIND_FOUND : ST_BIND_NO_ADDR;
        end else begin
          r.status = ST_ALLOC;
          if (keep_rel_ok) begin
            r.rel_ip   = keep_rel_ip;
            r.rel_port = keep_rel_port;
            r.rel_ok   = 1'b1;
          end
          if (keep_life_ok) begin
            r.life    = keep_life;
            r.life_ok = 1'b1;
          end
        end
      end else begin
        r.status = ST_OTHER_TYPE;
      end
    end
    clear_parse();
    return 1'b1;
  endfunction

  // ---------------------------------------------------------------------------
  // Scoreboard
  // ---------------------------------------------------------------------------
  stun_result_t due_results[$];
  dgram_note_t  dgram_notes[$];   // one per datagram in flight, in send order
  int           n_errs = 0;
  int           n_results = 0;
  int           n_msgs = 0;
  int           n_bytes = 0;
  int           st_seen[8];

  task automatic note_mismatch(string what);
    $display("ERROR @%0t: %s", $time, what);
    n_errs++;
  endtask

  task automatic cmp_field(string name, logic [63:0] got, logic [63:0] want);
    if (got !== want)
      note_mismatch($sformatf("%s: got %0h, want %0h", name, got, want));
  endtask

  task automatic check_result();
    stun_result_t want;
    if (due_results.size() == 0) begin
      note_mismatch("result beat with nothing due");
      return;
    end
    want = due_results.pop_front();
    n_results++;
    st_seen[want.status]++;
    cmp_field("status", 64'(status), 64'(want.status));
    cmp_field("message_type", 64'(message_type), 64'(want.msg_type));
    cmp_field("mapped_ip", 64'(mapped_ip), 64'(want.map_ip));
    cmp_field("mapped_port", 64'(mapped_port), 64'(want.map_port));
    cmp_field("mapped_valid", 64'(mapped_valid), 64'(want.map_ok));
    cmp_field("relayed_ip", 64'(relayed_ip), 64'(want.rel_ip));
    cmp_field("relayed_port", 64'(relayed_port), 64'(want.rel_port));
    cmp_field("relayed_valid", 64'(relayed_valid), 64'(want.rel_ok));
    cmp_field("lifetime_seconds", 64'(lifetime_seconds), 64'(want.life));
    cmp_field("lifetime_valid", 64'(lifetime_valid), 64'(want.life_ok));
    cmp_field("txid_high", 64'(txid_high), 64'(want.tx_hi));
    cmp_field("txid_low", txid_low, want.tx_lo);
  endtask

  // Both sides are sampled at the rising edge, before any of this edge's updates land.
  always @(posedge clk) begin
    stun_result_t pred;
    dgram_note_t  note;
    if (rst) begin
      clear_parse();
    end else begin
      if (in_valid && in_ready) begin
        if (parse_byte(data_byte, last_byte, pred)) begin
          note = dgram_notes.pop_front();
          due_results = {due_results, (note.pin ? note.res : pred)};
        end
      end
      if (out_valid && out_ready) check_result();
    end
  end

  // ---------------------------------------------------------------------------
  // Datagram construction and driving
  // ---------------------------------------------------------------------------
  logic [7:0] dgram[$];

  function automatic attr_t mk_addr(logic [15:0] t, logic [15:0] len, logic [7:0] fam,
                                    logic [15:0] port, logic [31:0] ip);
    return {t, len, 8'h00, fam, port, ip};
  endfunction

  function automatic attr_t mk_life(logic [15:0] len, logic [31:0] secs);
    return {A_LIFETIME, len, secs, 32'h5A5A_0FF0};
  endfunction

  function automatic msg_spec_t mk_msg(logic [15:0] mtype, logic [31:0] cookie,
                                       logic [95:0] txid, int len_adj, int cut, int total,
                                       int nattr, attr_t a0, attr_t a1, attr_t a2,
                                       bit pin, status_t pin_st);
    msg_spec_t s;
    s.mtype    = mtype;
    s.cookie   = cookie;
    s.txid     = txid;
    s.len_adj  = len_adj;
    s.cut      = cut;
    s.total    = total;
    s.nattr    = nattr;
    s.attrs[0] = a0;
    s.attrs[1] = a1;
    s.attrs[2] = a2;
    s.pin      = pin;
    s.pin_st   = pin_st;
    return s;
  endfunction

  function automatic void build_dgram(msg_spec_t s);
    logic [7:0]  body[$];
    logic [15:0] body_len;
    attr_t       a;
    body = {};
    for (int k = 0; k < s.nattr; k++) begin
      a = s.attrs[k];
      body = {body, a.atype[15:8]};
      body = {body, a.atype[7:0]};
      body = {body, a.alen[15:8]};
      body = {body, a.alen[7:0]};
      for (int i = 0; i < int'(a.alen); i++)
        body = {body, ((i < 8) ? a.val[63 - 8 * i -: 8] : 8'($urandom))};
      while (body.size() % 4 != 0) body = {body, 8'($urandom)};
    end
    body_len = 16'(body.size() + s.len_adj);
    dgram = {};
    dgram = {dgram, s.mtype[15:8]};
    dgram = {dgram, s.mtype[7:0]};
    dgram = {dgram, body_len[15:8]};
    dgram = {dgram, body_len[7:0]};
    for (int i = 0; i < 4; i++) dgram = {dgram, s.cookie[31 - 8 * i -: 8]};
    for (int i = 0; i < 12; i++) dgram = {dgram, s.txid[95 - 8 * i -: 8]};
    foreach (body[i]) dgram = {dgram, body[i]};
    while (dgram.size() < s.total) dgram = {dgram, 8'($urandom)};
    if (s.cut > 0)
      while (dgram.size() > s.cut) void'(dgram.pop_back());
  endfunction

  task automatic send_byte(logic [7:0] b, bit last);
    bit took;
    while ($urandom_range(99) < src_idle) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid  <= 1'b1;
    data_byte <= b;
    last_byte <= last;
    // in_ready is settled by the falling edge; the beat goes at the next rising edge
    do begin
      @(negedge clk);
      took = in_ready;
      @(posedge clk);
    end while (!took);
    n_bytes++;
  endtask

  task automatic send_msg(msg_spec_t s);
    dgram_note_t note;
    build_dgram(s);
    note.pin = s.pin;
    note.res = '0;
    if (s.pin) begin
      note.res.status = s.pin_st;
      if (s.pin_st != ST_SHORT) begin
        note.res.msg_type = s.mtype;
        note.res.tx_hi    = s.txid[95:64];
        note.res.tx_lo    = s.txid[63:0];
      end
    end
    dgram_notes = {dgram_notes, note};
    foreach (dgram[i]) send_byte(dgram[i], i == dgram.size() - 1);
    n_msgs++;
  endtask

  // ---------------------------------------------------------------------------
  // Random datagrams: mostly well-formed binding/allocate answers with random content,
  // the rest bad cookies, odd types, wrong lengths, cut or padded datagrams.
  // ---------------------------------------------------------------------------
  function automatic attr_t rand_attr();
    int          pick;
    logic [15:0] port;
    logic [31:0] ip;
    logic [7:0]  fam;
    logic [15:0] alen;
    pick = $urandom_range(9);
    port = 16'($urandom);
    ip   = $urandom;
    case ($urandom_range(9))
      0: begin
        port = '1;
        ip   = '1;
      end
      1: begin
        port = '0;
        ip   = '0;
      end
      default: ;
    endcase
    fam  = ($urandom_range(99) < 85) ? FAMILY_IPV4 : 8'($urandom);
    alen = ($urandom_range(99) < 80) ? 16'd8 : 16'($urandom_range(12));
    if (pick < 3) return mk_addr(A_XOR_MAPPED, alen, fam, port, ip);
    if (pick < 4) return mk_addr(A_MAPPED, alen, fam, port, ip);
    if (pick < 6) return mk_addr(A_XOR_RELAYED, alen, fam, port, ip);
    if (pick < 8)
      return mk_life(($urandom_range(99) < 70) ? 16'd4 : 16'($urandom_range(10)), $urandom);
    return {16'($urandom), 16'($urandom_range(12)), $urandom, $urandom};
  endfunction

  function automatic msg_spec_t rand_msg();
    msg_spec_t s;
    int        pick;
    pick     = $urandom_range(99);
    s.mtype  = (pick < 40) ? T_BIND_OK : (pick < 80) ? T_ALLOC_OK : 16'($urandom);
    s.cookie = ($urandom_range(99) < 90) ? MAGIC_COOKIE : $urandom;
    s.txid   = {$urandom, $urandom, $urandom};
    s.len_adj = ($urandom_range(99) < 80) ? 0 : int'($urandom_range(24)) - 12;
    s.cut     = ($urandom_range(99) < 85) ? 0 : int'($urandom_range(60, 1));
    s.total   = ($urandom_range(99) < 10) ? int'($urandom_range(60, 20)) : 0;
    s.nattr   = $urandom_range(3);
    for (int k = 0; k < 3; k++) s.attrs[k] = rand_attr();
    s.pin    = PREDICTED;
    s.pin_st = ST_BIND_FOUND;
    return s;
  endfunction

  // ---------------------------------------------------------------------------
  // Directed table
  // ---------------------------------------------------------------------------
  msg_spec_t dir_tab[$];

  initial begin
    int guard;
    int dir_bytes;

    // one byte only, and one byte short of a header
    dir_tab = {dir_tab, mk_msg(T_BIND_OK, MAGIC_COOKIE, TX_A, 0, 1, 0, 0,
                               NO_ATTR, NO_ATTR, NO_ATTR, PINNED, ST_SHORT)};
    dir_tab = {dir_tab, mk_msg(T_BIND_OK, MAGIC_COOKIE, TX_A, 0, 19, 0, 0,
                               NO_ATTR, NO_ATTR, NO_ATTR, PINNED, ST_SHORT)};
    // bare header, binding, all-ones txid: no address found
    dir_tab = {dir_tab, mk_msg(T_BIND_OK, MAGIC_COOKIE, '1, 0, 0, 0, 0,
                               NO_ATTR, NO_ATTR, NO_ATTR, PINNED, ST_BIND_NO_ADDR)};
    // bad cookie with all-ones type and zero txid; the attribute must not show
    dir_tab = {dir_tab, mk_msg(16'hFFFF, 32'hFFFF_FFFF, '0, 0, 0, 0, 1,
                               mk_addr(A_XOR_MAPPED, 16'd8, FAMILY_IPV4, 16'h1234,
                                       32'h0A00_0001),
                               NO_ATTR, NO_ATTR, PINNED, ST_BAD_COOKIE)};
    // error response type: other type, attributes dropped
    dir_tab = {dir_tab, mk_msg(16'h0111, MAGIC_COOKIE, TX_A, 0, 0, 0, 2,
                               mk_addr(A_XOR_MAPPED, 16'd8, FAMILY_IPV4, 16'h1234,
                                       32'h0A00_0001),
                               mk_life(16'd4, 32'd600), NO_ATTR, PINNED, ST_OTHER_TYPE)};
    // binding with one XOR-MAPPED address
    dir_tab = {dir_tab, mk_msg(T_BIND_OK, MAGIC_COOKIE, TX_A, 0, 0, 0, 1,
                               mk_addr(A_XOR_MAPPED, 16'd8, FAMILY_IPV4, 16'hF1A2,
                                       32'hE1BA_A443),
                               NO_ATTR, NO_ATTR, PREDICTED, ST_BIND_FOUND)};
    // binding: plain MAPPED first, so it wins over the XOR one
    dir_tab = {dir_tab, mk_msg(T_BIND_OK, MAGIC_COOKIE, TX_A, 0, 0, 0, 2,
                               mk_addr(A_MAPPED, 16'd8, FAMILY_IPV4, 16'd3478, 32'hC0A8_0101),
                               mk_addr(A_XOR_MAPPED, 16'd8, FAMILY_IPV4, 16'h0001,
                                       32'h1111_1111),
                               NO_ATTR, PREDICTED, ST_BIND_FOUND)};
    // binding: IPv6 family skipped, then a 12-byte MAPPED that is kept
    dir_tab = {dir_tab, mk_msg(T_BIND_OK, MAGIC_COOKIE, TX_A, 0, 0, 0, 3,
                               mk_addr(A_MAPPED, 16'd8, 8'h02, 16'h5555, 32'h2222_2222),
                               mk_addr(A_MAPPED, 16'd12, FAMILY_IPV4, 16'h0050, 32'h0808_0808),
                               mk_addr(A_XOR_MAPPED, 16'd8, FAMILY_IPV4, 16'h0002,
                                       32'h3333_3333),
                               PREDICTED, ST_BIND_FOUND)};
    // allocate with relayed, mapped and lifetime
    dir_tab = {dir_tab, mk_msg(T_ALLOC_OK, MAGIC_COOKIE, TX_A, 0, 0, 0, 3,
                               mk_addr(A_XOR_RELAYED, 16'd8, FAMILY_IPV4, 16'hC350,
                                       32'h6B21_0107),
                               mk_addr(A_XOR_MAPPED, 16'd8, FAMILY_IPV4, 16'h8080,
                                       32'h5D18_2201),
                               mk_life(16'd4, 32'd600), PREDICTED, ST_ALLOC)};
    // allocate: lifetime too short, zero-length attribute, lifetime of 6 with padding
    dir_tab = {dir_tab, mk_msg(T_ALLOC_OK, MAGIC_COOKIE, TX_A, 0, 0, 0, 3,
                               mk_life(16'd3, 32'hAAAA_AAAA), {16'h8028, 16'd0, 64'h0},
                               mk_life(16'd6, 32'h0001_2345), PREDICTED, ST_ALLOC)};
    // walk end: declared length leaves out the last attribute
    dir_tab = {dir_tab, mk_msg(T_ALLOC_OK, MAGIC_COOKIE, TX_A, -12, 0, 0, 3,
                               mk_life(16'd4, 32'd300),
                               mk_addr(A_XOR_MAPPED, 16'd8, FAMILY_IPV4, 16'h0101,
                                       32'h0102_0304),
                               mk_addr(A_XOR_RELAYED, 16'd8, FAMILY_IPV4, 16'h0202,
                                       32'h0506_0708),
                               PREDICTED, ST_ALLOC)};
    // truncated attribute: datagram ends inside the relayed address value
    dir_tab = {dir_tab, mk_msg(T_ALLOC_OK, MAGIC_COOKIE, TX_A, 0, 20 + 12 + 7, 0, 2,
                               mk_addr(A_XOR_MAPPED, 16'd8, FAMILY_IPV4, 16'h0303,
                                       32'h0A0B_0C0D),
                               mk_addr(A_XOR_RELAYED, 16'd8, FAMILY_IPV4, 16'h0404,
                                       32'h0E0F_1011),
                               NO_ATTR, PREDICTED, ST_ALLOC)};
    // extreme address and lifetime values
    dir_tab = {dir_tab, mk_msg(T_ALLOC_OK, MAGIC_COOKIE, '1, 0, 0, 0, 3,
                               mk_addr(A_XOR_RELAYED, 16'd8, FAMILY_IPV4, 16'hFFFF,
                                       32'hFFFF_FFFF),
                               mk_addr(A_XOR_MAPPED, 16'd8, FAMILY_IPV4, 16'h0000,
                                       32'h0000_0000),
                               mk_life(16'd8, 32'hFFFF_FFFF), PREDICTED, ST_ALLOC)};
    // binding: 7-byte address rejected, unknown 5-byte attribute, then XOR-MAPPED
    dir_tab = {dir_tab, mk_msg(T_BIND_OK, MAGIC_COOKIE, '0, 0, 0, 0, 3,
                               mk_addr(A_MAPPED, 16'd7, FAMILY_IPV4, 16'h7777, 32'h7777_7777),
                               {16'h8022, 16'd5, 64'h0102_0304_0506_0708},
                               mk_addr(A_XOR_MAPPED, 16'd8, FAMILY_IPV4, 16'hFFFF,
                                       32'hFFFF_FFFF),
                               PREDICTED, ST_BIND_FOUND)};
    // allocate ignores plain MAPPED; zero lifetime
    dir_tab = {dir_tab, mk_msg(T_ALLOC_OK, MAGIC_COOKIE, TX_A, 0, 0, 0, 3,
                               mk_addr(A_MAPPED, 16'd8, FAMILY_IPV4, 16'h1111, 32'h4444_4444),
                               mk_life(16'd4, 32'd0),
                               mk_addr(A_XOR_MAPPED, 16'd8, FAMILY_IPV4, 16'h2222,
                                       32'h5555_5555),
                               PREDICTED, ST_ALLOC)};
    // overlong: 300 bytes with a huge declared length; bytes past the cap are dropped
    dir_tab = {dir_tab, mk_msg(T_ALLOC_OK, MAGIC_COOKIE, TX_A, 2200, 0, 300, 2,
                               mk_addr(A_XOR_RELAYED, 16'd8, FAMILY_IPV4, 16'h9999,
                                       32'h0102_0304),
                               mk_life(16'd4, 32'd3600), NO_ATTR, PREDICTED, ST_ALLOC)};

    @(negedge rst);
    @(posedge clk);

    // sender idles lightly, receiver stalls heavily
    src_idle = 15;
    dst_idle = 71;
    foreach (dir_tab[i]) send_msg(dir_tab[i]);
    dir_bytes = n_bytes;

    while (n_bytes - dir_bytes < RAND_BYTES) begin
      if (n_bytes - dir_bytes < RAND_BYTES / 3) begin
        src_idle = 15;
        dst_idle = 71;
      end else if (n_bytes - dir_bytes < 2 * RAND_BYTES / 3) begin
        src_idle = 71;
        dst_idle = 15;
      end else begin
        src_idle = 0;
        dst_idle = 0;
      end
      send_msg(rand_msg());
    end
    in_valid <= 1'b0;

    // drain: result shows in the cycle after the last byte, plus receiver stalls
    repeat (2) @(posedge clk);
    guard = 0;
    while (due_results.size() != 0 && guard < 20000) begin
      @(posedge clk);
      guard++;
    end
    repeat (4) @(posedge clk);
    if (due_results.size() != 0)
      note_mismatch($sformatf("%0d results never came out", due_results.size()));

    $display("Covered %0d datagrams, %0d bytes; %0d results compared, %0d mismatches",
             n_msgs, n_bytes, n_results, n_errs);
    $display("Outcomes: found %0d, allocate %0d, short %0d, bad cookie %0d, other %0d, no addr %0d",
             st_seen[ST_BIND_FOUND], st_seen[ST_ALLOC], st_seen[ST_SHORT],
             st_seen[ST_BAD_COOKIE], st_seen[ST_OTHER_TYPE], st_seen[ST_BIND_NO_ADDR]);
    if (n_errs == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  // Hang guard: far beyond the slowest legal run.
  initial begin
    #10_000_000;
    $display("FAIL");
    $finish;
  end

endmodule

// ===== sim.f =====
hdl/stunrp_pkg.sv
hdl/stun_response_parser_top.sv
tb/tb_top.sv
